[src/sfs_pkg.sv]
// Shared types and constants for the servo frame scheduler.
`timescale 1ns / 1ps
package sfs_pkg;

    localparam int C_NUM_CHANNELS = 8;
    localparam int C_WIDTH_BITS   = 16;
    localparam int C_MILLIS_BITS  = 32;
    localparam int C_CHAN_BITS    = 4;

    localparam logic [4:0]  C_SLOT_LAST  = 5'd19;
    localparam logic [4:0]  C_PREP_LAST  = 5'd24;
    localparam logic [3:0]  C_SLOT_FIRST = 4'd2;
    localparam logic [3:0]  C_SLOT_END   = 4'd9;
    localparam logic [15:0] C_ON_DELAY   = 16'd15;
    localparam logic [7:0]  C_FS_HIGH    = 8'd10;
    localparam logic [7:0]  C_FS_LOAD    = 8'd11;
    localparam logic [7:0]  C_FS_FULL    = 8'd255;
    localparam logic [1:0]  C_FS_EVERY   = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_PULSE = 2'd1,
        CMD_WIDTH = 2'd2
    } t_cmd;

    typedef struct packed {
        logic                     start;
        logic [C_CHAN_BITS-1:0]   channel;
        logic [C_WIDTH_BITS-1:0]  on_compare;
        logic                     prepare;
        logic                     radio_live;
        logic [C_MILLIS_BITS-1:0] millis;
    } t_item_res;

endpackage

[src/sfs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module sfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 9
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/sfs_ctrl.sv]
// Frame timing, fail-safe counter and millisecond counter for each accepted item.
`timescale 1ns / 1ps
module sfs_ctrl
    import sfs_pkg::*;
#(
    parameter int NUM_CHANNELS = C_NUM_CHANNELS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_data,
    input  logic                    i_accept,
    input  logic [1:0]              i_cmd,
    input  logic [C_WIDTH_BITS-1:0] i_timer_now,
    output t_item_res               o_res
);

    logic [4:0]               r_slot_cnt, n_slot_cnt;
    logic [4:0]               r_prep_cnt, n_prep_cnt;
    logic [1:0]               r_half, n_half;
    logic [7:0]               r_fs_cnt, n_fs_cnt;
    logic                     r_radio, n_radio;
    logic                     r_no_radio;
    logic [C_MILLIS_BITS-1:0] r_millis, n_millis;

    logic [3:0] slot;
    logic [3:0] slot_ch;
    logic [1:0] half_inc;
    logic       start;
    logic       prep;

    always_comb begin
        n_slot_cnt = r_slot_cnt;
        n_prep_cnt = r_prep_cnt;
        n_half     = r_half;
        n_fs_cnt   = r_fs_cnt;
        n_radio    = r_radio;
        n_millis   = r_millis;
        start      = 1'b0;
        prep       = 1'b0;
        slot       = 4'd0;
        slot_ch    = 4'd0;
        half_inc   = r_half + 2'd1;

        if (i_accept) begin
            unique case (t_cmd'(i_cmd))
                CMD_TICK: begin
                    n_millis   = r_millis + 1'b1;
                    n_slot_cnt = (r_slot_cnt == C_SLOT_LAST) ? 5'd0 : r_slot_cnt + 5'd1;
                    n_prep_cnt = (r_prep_cnt == C_PREP_LAST) ? 5'd0 : r_prep_cnt + 5'd1;
                    slot       = n_slot_cnt[4:1];
                    slot_ch    = slot - 4'd1;
                    start      = n_slot_cnt[0] && (slot >= C_SLOT_FIRST)
                                 && (slot <= C_SLOT_END)
                                 && (slot_ch <= C_CHAN_BITS'(NUM_CHANNELS));
                    if (n_prep_cnt == 5'd0 && !r_no_radio) begin
                        prep = 1'b1;
                        if (half_inc >= C_FS_EVERY) begin
                            n_half = 2'd0;
                            priority if (r_fs_cnt == 8'd0) begin
                                n_radio = 1'b0;
                            end else if (r_fs_cnt >= C_FS_HIGH) begin
                                n_radio  = 1'b1;
                                n_fs_cnt = C_FS_LOAD;
                            end else begin
                                n_fs_cnt = r_fs_cnt - 8'd1;
                            end
                        end else begin
                            n_half = half_inc;
                        end
                    end
                end
                CMD_PULSE: begin
                    if (r_fs_cnt != C_FS_FULL) begin
                        n_fs_cnt = r_fs_cnt + 8'd1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cfg_we && i_cfg_data) begin
            n_radio = 1'b1;
        end

        o_res.start      = start;
        o_res.channel    = start ? slot_ch : 4'd0;
        o_res.on_compare = start ? i_timer_now + C_ON_DELAY : '0;
        o_res.prepare    = prep;
        o_res.radio_live = r_no_radio | n_radio;
        o_res.millis     = n_millis;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_cnt <= '0;
            r_prep_cnt <= '0;
            r_half     <= '0;
            r_fs_cnt   <= '0;
            r_radio    <= 1'b0;
            r_no_radio <= 1'b0;
            r_millis   <= '0;
        end else begin
            r_slot_cnt <= n_slot_cnt;
            r_prep_cnt <= n_prep_cnt;
            r_half     <= n_half;
            r_fs_cnt   <= n_fs_cnt;
            r_radio    <= n_radio;
            r_millis   <= n_millis;
            if (i_cfg_we) begin
                r_no_radio <= i_cfg_data;
            end
        end
    end

endmodule

[src/servo_frame_scheduler_failsafe.sv]
// Top level of the servo frame scheduler with radio fail-safe.
// An item passes through the first stage with the width RAM read, then through the output register.
// Throughput: one item per cycle while i_ready does not stall the output; the pulse-width RAM read is the extra stage.
// Reset (synchronous, active low) clears all counters, flags and the valid bits of the pipeline stages.
// Pulse widths read as zero until written, tracked by one valid flag per width RAM entry.
`timescale 1ns / 1ps
module servo_frame_scheduler_failsafe
    import sfs_pkg::*;
#(
    parameter int NUM_CHANNELS = C_NUM_CHANNELS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_cmd,
    input  logic [C_WIDTH_BITS-1:0]  i_timer_now,
    input  logic [C_CHAN_BITS-1:0]   i_channel,
    input  logic [C_WIDTH_BITS-1:0]  i_width,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_start_valid,
    output logic [C_CHAN_BITS-1:0]   o_start_channel,
    output logic [C_WIDTH_BITS-1:0]  o_on_compare,
    output logic [C_WIDTH_BITS-1:0]  o_off_compare,
    output logic                     o_prepare_outputs,
    output logic                     o_radio_live,
    output logic [C_MILLIS_BITS-1:0] o_millis
);

    localparam int DEPTH = NUM_CHANNELS + 1;
    localparam int AW    = $clog2(DEPTH);

    t_item_res              res;
    logic                   accept;
    logic                   s1_adv;
    logic                   wr_en;
    logic [C_WIDTH_BITS-1:0] rdata;
    logic [C_WIDTH_BITS-1:0] width_used;

    logic                    r_s1_valid;
    t_item_res               r_s1_res;
    logic                    r_s1_wvld;
    logic [DEPTH-1:0]        r_wvalid;
    logic                    r_out_valid;
    t_item_res               r_out_res;
    logic [C_WIDTH_BITS-1:0] r_out_off;

    assign o_ready = !r_s1_valid || !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign s1_adv  = r_s1_valid && (!r_out_valid || i_ready);
    assign wr_en   = accept && (t_cmd'(i_cmd) == CMD_WIDTH)
                     && (i_channel <= C_CHAN_BITS'(NUM_CHANNELS));

    sfs_ctrl #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_cmd      (i_cmd),
        .i_timer_now(i_timer_now),
        .o_res      (res)
    );

    sfs_ram #(
        .WIDTH(C_WIDTH_BITS),
        .DEPTH(DEPTH)
    ) u_width_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(i_channel[AW-1:0]),
        .i_wdata(i_width),
        .i_re   (accept),
        .i_raddr(res.channel[AW-1:0]),
        .o_rdata(rdata)
    );

    assign width_used = (r_s1_wvld && r_s1_res.start) ? rdata : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wvalid    <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (wr_en) begin
                r_wvalid[i_channel[AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res  <= res;
            r_s1_wvld <= r_wvalid[res.channel[AW-1:0]];
        end
        if (s1_adv) begin
            r_out_res <= r_s1_res;
            r_out_off <= r_s1_res.start ? r_s1_res.on_compare + width_used : '0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_start_valid     = r_out_res.start;
    assign o_start_channel   = r_out_res.channel;
    assign o_on_compare      = r_out_res.on_compare;
    assign o_off_compare     = r_out_off;
    assign o_prepare_outputs = r_out_res.prepare;
    assign o_radio_live      = r_out_res.radio_live;
    assign o_millis          = r_out_res.millis;

endmodule
